>>> rtl/core/acbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acbd_pkg: shared types and constants of the audio cpu bus decoder
// Request codes, memory-map constants and the stage record between
// the access stage and the result stage.
// ----------------------------------------------------------------------------
package acbd_pkg;

    localparam int ADDR_W         = 16;
    localparam int DATA_W         = 8;
    localparam int DSP_REG_COUNT  = 128;
    localparam int BOOT_ROM_BYTES = 64;
    localparam int DSP_IDX_W      = $clog2(DSP_REG_COUNT);
    localparam int ROM_IDX_W      = $clog2(BOOT_ROM_BYTES);
    localparam int CPU_PORTS      = 4;
    localparam int PADDR_W        = 4;
    localparam int PDATA_W        = 32;

    typedef logic [1:0] req_t;
    localparam req_t REQ_READ  = 2'd0;
    localparam req_t REQ_WRITE = 2'd1;
    localparam req_t REQ_IDLE  = 2'd2;
    localparam req_t REQ_LOAD  = 2'd3;

    typedef logic [1:0] src_t;
    localparam src_t SRC_DIRECT = 2'd0;
    localparam src_t SRC_RAM    = 2'd1;
    localparam src_t SRC_DSP    = 2'd2;
    localparam src_t SRC_ROM    = 2'd3;

    localparam logic [11:0]       PORT_PAGE    = 12'h00f;
    localparam logic [ADDR_W-1:0] ROM_BASE     = 16'hffc0;
    localparam logic [ADDR_W-1:0] CONTROL_PORT = 16'h00f1;
    localparam logic [ADDR_W-1:0] DSP_ADDR_PORT = 16'h00f2;
    localparam logic [ADDR_W-1:0] DSP_DATA_PORT = 16'h00f3;
    localparam int                ROM_ENABLE_BIT = 7;

    localparam logic [3:0] PORT_DSP_ADDR = 4'h2;
    localparam logic [3:0] PORT_DSP_DATA = 4'h3;
    localparam logic [3:0] PORT_CPU0     = 4'h4;
    localparam logic [3:0] PORT_CPU1     = 4'h5;
    localparam logic [3:0] PORT_CPU2     = 4'h6;
    localparam logic [3:0] PORT_CPU3     = 4'h7;
    localparam logic [3:0] PORT_RAM0     = 4'h8;
    localparam logic [3:0] PORT_RAM1     = 4'h9;

    typedef logic [CPU_PORTS-1:0][DATA_W-1:0] cpu_ports_t;

    typedef struct packed {
        logic              valid;
        src_t              src;
        logic [DATA_W-1:0] direct;
    } stage_t;

endpackage

>>> rtl/core/acbd_apb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acbd_apb: configuration register port
// Holds the four cpu input port bytes, written and read over apb.
// ----------------------------------------------------------------------------
module acbd_apb (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [acbd_pkg::PADDR_W-1:0]   paddr,
    input  logic [acbd_pkg::PDATA_W-1:0]   pwdata,
    output logic [acbd_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output acbd_pkg::cpu_ports_t           cpu_ports
);
    import acbd_pkg::*;

    cpu_ports_t      ports_reg;
    logic [1:0]      idx;
    logic            wr_en;

    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = {{(PDATA_W-DATA_W){1'b0}}, ports_reg[idx]};
    assign cpu_ports = ports_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ports_reg <= '0;
        end else if (wr_en) begin
            ports_reg[idx] <= pwdata[DATA_W-1:0];
        end
    end

endmodule

>>> rtl/core/acbd_access.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acbd_access: request decode and memory access stage
// Decodes each request, updates ram, dsp registers, boot rom and the
// port latches, and registers the read data with its source select.
// ----------------------------------------------------------------------------
module acbd_access (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_req_type,
    input  logic [acbd_pkg::ADDR_W-1:0]   s_addr,
    input  logic [acbd_pkg::DATA_W-1:0]   s_write_data,
    input  acbd_pkg::cpu_ports_t          cpu_ports,
    input  logic                          stage_free,
    output acbd_pkg::stage_t              stage,
    output logic [acbd_pkg::DATA_W-1:0]   ram_q,
    output logic [acbd_pkg::DATA_W-1:0]   dsp_q,
    output logic [acbd_pkg::DATA_W-1:0]   rom_q
);
    import acbd_pkg::*;

    logic [DATA_W-1:0] ram_mem [2**ADDR_W];
    logic [DATA_W-1:0] dsp_mem [DSP_REG_COUNT];
    logic [DATA_W-1:0] rom_mem [BOOT_ROM_BYTES];

    logic [DATA_W-1:0] latch_reg, latch_next;
    logic              rom_en_reg, rom_en_next;
    stage_t            stage_reg, stage_next;
    logic [DATA_W-1:0] ram_q_reg, dsp_q_reg, rom_q_reg;

    logic accept, is_read, is_write, is_load, port_page, dsp_wr;
    src_t              src;
    logic [DATA_W-1:0] direct;

    assign s_ready   = !stage_reg.valid || stage_free;
    assign accept    = s_valid && s_ready;
    assign is_read   = (s_req_type == REQ_READ);
    assign is_write  = (s_req_type == REQ_WRITE);
    assign is_load   = (s_req_type == REQ_LOAD);
    assign port_page = (s_addr[ADDR_W-1:4] == PORT_PAGE);
    assign dsp_wr    = is_write && (s_addr == DSP_DATA_PORT) && !latch_reg[DATA_W-1];

    // read source decode
    always_comb begin
        src    = SRC_DIRECT;
        direct = '0;
        if (is_read) begin
            if (port_page) begin
                case (s_addr[3:0])
                    PORT_DSP_ADDR: direct = latch_reg;
                    PORT_DSP_DATA: src = SRC_DSP;
                    PORT_CPU0, PORT_CPU1, PORT_CPU2, PORT_CPU3: begin
                        direct = cpu_ports[s_addr[1:0]];
                    end
                    PORT_RAM0, PORT_RAM1: src = SRC_RAM;
                    default: direct = '0;
                endcase
            end else if (s_addr >= ROM_BASE && rom_en_reg) begin
                src = SRC_ROM;
            end else begin
                src = SRC_RAM;
            end
        end
    end

    always_comb begin
        latch_next  = latch_reg;
        rom_en_next = rom_en_reg;
        if (accept && is_write) begin
            if (s_addr == CONTROL_PORT) begin
                rom_en_next = s_write_data[ROM_ENABLE_BIT];
            end
            if (s_addr == DSP_ADDR_PORT) begin
                latch_next = s_write_data;
            end
        end
    end

    always_comb begin
        stage_next = stage_reg;
        if (accept) begin
            stage_next.valid  = 1'b1;
            stage_next.src    = src;
            stage_next.direct = direct;
        end else if (stage_free) begin
            stage_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latch_reg       <= '0;
            rom_en_reg      <= 1'b0;
            stage_reg.valid <= 1'b0;
        end else begin
            latch_reg       <= latch_next;
            rom_en_reg      <= rom_en_next;
            stage_reg.valid <= stage_next.valid;
        end
        stage_reg.src    <= stage_next.src;
        stage_reg.direct <= stage_next.direct;
    end

    // audio ram
    always_ff @(posedge aclk) begin
        if (accept && is_write) begin
            ram_mem[s_addr] <= s_write_data;
        end
        if (accept && is_read) begin
            ram_q_reg <= ram_mem[s_addr];
        end
    end

    // dsp registers
    always_ff @(posedge aclk) begin
        if (accept && dsp_wr) begin
            dsp_mem[latch_reg[DSP_IDX_W-1:0]] <= s_write_data;
        end
        if (accept && is_read) begin
            dsp_q_reg <= dsp_mem[latch_reg[DSP_IDX_W-1:0]];
        end
    end

    // boot rom
    always_ff @(posedge aclk) begin
        if (accept && is_load) begin
            rom_mem[s_addr[ROM_IDX_W-1:0]] <= s_write_data;
        end
        if (accept && is_read) begin
            rom_q_reg <= rom_mem[s_addr[ROM_IDX_W-1:0]];
        end
    end

    assign stage = stage_reg;
    assign ram_q = ram_q_reg;
    assign dsp_q = dsp_q_reg;
    assign rom_q = rom_q_reg;

endmodule

>>> rtl/core/acbd_result.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acbd_result: result register
// Selects the read byte from the access stage and holds it until taken.
// ----------------------------------------------------------------------------
module acbd_result (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  acbd_pkg::stage_t              stage,
    input  logic [acbd_pkg::DATA_W-1:0]   ram_q,
    input  logic [acbd_pkg::DATA_W-1:0]   dsp_q,
    input  logic [acbd_pkg::DATA_W-1:0]   rom_q,
    output logic                          stage_free,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [acbd_pkg::DATA_W-1:0]   m_read_data
);
    import acbd_pkg::*;

    logic              valid_reg, valid_next;
    logic [DATA_W-1:0] data_reg, data_next, sel_data;

    assign stage_free = !valid_reg || m_ready;

    always_comb begin
        case (stage.src)
            SRC_RAM: sel_data = ram_q;
            SRC_DSP: sel_data = dsp_q;
            SRC_ROM: sel_data = rom_q;
            default: sel_data = stage.direct;
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (stage_free) begin
            valid_next = stage.valid;
            data_next  = sel_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign m_valid     = valid_reg;
    assign m_read_data = data_reg;

endmodule

>>> rtl/core/audio_cpu_bus_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_cpu_bus_decoder_unit: 64 KB audio cpu bus with port page decode
// Each request on the s_ channel is a read, write, idle or boot rom load.
// Every request gives exactly one byte on the m_ channel: the read byte
// for a read, zero for all others.
// The cpu input ports F4..F7 are set over the apb port, registers at
// byte addresses 0, 4, 8 and 12; write them only while the bus is idle.
// Decode and the synchronous ram, dsp register and boot rom access form
// the access stage; the result register follows it. One request is taken
// every cycle while the receiver keeps up, set by the single
// ram port that serves either the read or the write of a request.
// When the receiver stalls, the result register and the access stage
// fill and s_ready falls; nothing is lost.
// Reset clears the dsp address latch, the rom enable, the cpu ports and
// both stage valids; ram, dsp registers and boot rom keep no reset value.
// ----------------------------------------------------------------------------
module audio_cpu_bus_decoder_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_req_type,
    input  logic [acbd_pkg::ADDR_W-1:0]   s_addr,
    input  logic [acbd_pkg::DATA_W-1:0]   s_write_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [acbd_pkg::DATA_W-1:0]   m_read_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [acbd_pkg::PADDR_W-1:0]  paddr,
    input  logic [acbd_pkg::PDATA_W-1:0]  pwdata,
    output logic [acbd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import acbd_pkg::*;

    cpu_ports_t        cpu_ports;
    stage_t            stage;
    logic              stage_free;
    logic [DATA_W-1:0] ram_q, dsp_q, rom_q;

    acbd_apb u_apb (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cpu_ports (cpu_ports)
    );

    acbd_access u_access (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_addr       (s_addr),
        .s_write_data (s_write_data),
        .cpu_ports    (cpu_ports),
        .stage_free   (stage_free),
        .stage        (stage),
        .ram_q        (ram_q),
        .dsp_q        (dsp_q),
        .rom_q        (rom_q)
    );

    acbd_result u_result (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .stage       (stage),
        .ram_q       (ram_q),
        .dsp_q       (dsp_q),
        .rom_q       (rom_q),
        .stage_free  (stage_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_data (m_read_data)
    );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: audio cpu bus decoder unit
// Directed and random bus requests through a valid/ready driver, results
// checked in order against a bus model that tracks ram, dsp registers,
// boot rom, the dsp address latch and the rom enable. The cpu input ports
// are reprogrammed over apb between phases while the bus is drained.
// Both channels idle at random, with two long receiver hold-offs.
// ----------------------------------------------------------------------------
module testbench;
    import acbd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned PHASE_ITEMS = 432;

    typedef struct {
        req_t              req;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
        logic [DATA_W-1:0] rdata;
        bit                drain;
    } bus_op_t;

    logic                aclk;
    logic                aresetn      = 1'b0;
    logic                s_valid      = 1'b0;
    logic                s_ready;
    logic [1:0]          s_req_type   = REQ_IDLE;
    logic [ADDR_W-1:0]   s_addr       = '0;
    logic [DATA_W-1:0]   s_write_data = '0;
    logic                m_valid;
    logic                m_ready      = 1'b0;
    logic [DATA_W-1:0]   m_read_data;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [PADDR_W-1:0]  paddr        = '0;
    logic [PDATA_W-1:0]  pwdata       = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    audio_cpu_bus_decoder_unit u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_addr       (s_addr),
        .s_write_data (s_write_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // bus model state
    logic [DATA_W-1:0] ram_img [0:65535];
    bit                ram_set [0:65535];
    logic [DATA_W-1:0] dsp_img [0:DSP_REG_COUNT-1];
    bit                dsp_set [0:DSP_REG_COUNT-1];
    logic [DATA_W-1:0] rom_img [0:BOOT_ROM_BYTES-1];
    bit                rom_set [0:BOOT_ROM_BYTES-1];
    logic [DATA_W-1:0] dsp_latch = '0;
    bit                rom_on    = 1'b0;
    logic [DATA_W-1:0] port_in [0:CPU_PORTS-1] = '{default: '0};

    bus_op_t           req_q[$];
    bus_op_t           rdata_q[$];
    logic [ADDR_W-1:0] touched_q[$];
    bus_op_t           cur_op;
    bus_op_t           got_op;

    int unsigned n_queued   = 0;
    int unsigned n_accepted = 0;
    int unsigned n_checked  = 0;
    int unsigned errors     = 0;
    int unsigned cycles     = 0;

    int unsigned send_gap   = 0;
    int unsigned send_run   = 0;
    bit          send_calm  = 1'b0;
    int unsigned recv_wait  = 0;
    int unsigned recv_run   = 0;
    bit          recv_calm  = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int unsigned draw_wait(inout int unsigned run_left, inout bit calm);
        if (run_left == 0) begin
            calm     = ($urandom_range(0, 2) == 0);
            run_left = $urandom_range(16, 96);
        end
        run_left--;
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    // true when a read here hits no ram, dsp or rom byte that was never written or loaded
    function automatic bit read_is_defined(logic [ADDR_W-1:0] a);
        if (a[15:4] == PORT_PAGE) begin
            case (a[3:0])
                PORT_DSP_DATA:        return dsp_set[dsp_latch[DSP_IDX_W-1:0]];
                PORT_RAM0, PORT_RAM1: return ram_set[a];
                default:              return 1'b1;
            endcase
        end
        if (a >= ROM_BASE && rom_on)
            return rom_set[a[ROM_IDX_W-1:0]];
        return ram_set[a];
    endfunction

    function automatic logic [DATA_W-1:0] bus_model_step(req_t req, logic [ADDR_W-1:0] a,
                                                         logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        r = '0;
        case (req)
            REQ_READ: begin
                if (a[15:4] == PORT_PAGE) begin
                    case (a[3:0])
                        PORT_DSP_ADDR:        r = dsp_latch;
                        PORT_DSP_DATA:        r = dsp_img[dsp_latch[DSP_IDX_W-1:0]];
                        PORT_CPU0, PORT_CPU1,
                        PORT_CPU2, PORT_CPU3: r = port_in[a[1:0]];
                        PORT_RAM0, PORT_RAM1: r = ram_img[a];
                        default:              r = '0;
                    endcase
                end else if (a >= ROM_BASE && rom_on) begin
                    r = rom_img[a[ROM_IDX_W-1:0]];
                end else begin
                    r = ram_img[a];
                end
            end
            REQ_WRITE: begin
                ram_img[a] = v;
                ram_set[a] = 1'b1;
                if (a == CONTROL_PORT) begin
                    rom_on = v[ROM_ENABLE_BIT];
                end else if (a == DSP_ADDR_PORT) begin
                    dsp_latch = v;
                end else if (a == DSP_DATA_PORT && dsp_latch < DSP_REG_COUNT) begin
                    dsp_img[dsp_latch[DSP_IDX_W-1:0]] = v;
                    dsp_set[dsp_latch[DSP_IDX_W-1:0]] = 1'b1;
                end
            end
            REQ_LOAD: begin
                rom_img[a[ROM_IDX_W-1:0]] = v;
                rom_set[a[ROM_IDX_W-1:0]] = 1'b1;
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // queue one request; a read of undefined bytes becomes a write there
    task automatic post(req_t req, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] v);
        bus_op_t op;
        op.req   = req;
        op.addr  = a;
        op.wdata = v;
        op.drain = ($urandom_range(0, 199) == 0);
        if (req == REQ_READ && !read_is_defined(a))
            op.req = REQ_WRITE;
        op.rdata = bus_model_step(op.req, op.addr, op.wdata);
        if (op.req == REQ_WRITE) begin
            touched_q.push_back(a);
            if (touched_q.size() > 256)
                void'(touched_q.pop_front());
        end
        req_q.push_back(op);
        n_queued++;
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || rdata_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic cfg_write(int unsigned idx, logic [DATA_W-1:0] d);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx * 4);
        pwdata  <= {24'($urandom), d};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        port_in[idx] = d;
    endtask

    task automatic run_phase(logic [DATA_W-1:0] p0, logic [DATA_W-1:0] p1,
                             logic [DATA_W-1:0] p2, logic [DATA_W-1:0] p3);
        int unsigned       stop;
        int unsigned       pick;
        int unsigned       n;
        logic [ADDR_W-1:0] a;
        logic [ROM_IDX_W-1:0] idx;
        wait_drained();
        repeat (4) @(posedge aclk);
        cfg_write(0, p0);
        cfg_write(1, p1);
        cfg_write(2, p2);
        cfg_write(3, p3);
        stop = n_queued + PHASE_ITEMS;
        while (n_queued < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                a = 16'($urandom);
                n = $urandom_range(0, 9);
                if (n < 2)
                    a = ROM_BASE | 16'($urandom_range(0, 63));
                else if (n == 2)
                    a = {PORT_PAGE, 4'($urandom)};
                post(REQ_WRITE, a, 8'($urandom));
            end else if (pick < 55) begin
                if (touched_q.size() == 0)
                    post(REQ_WRITE, 16'($urandom), 8'($urandom));
                else
                    post(REQ_READ, touched_q[$urandom_range(0, touched_q.size() - 1)],
                         8'($urandom));
            end else if (pick < 65) begin
                // dsp register access through the latch
                if ($urandom_range(0, 9) == 0)
                    post(REQ_WRITE, DSP_ADDR_PORT, 8'($urandom_range(128, 255)));
                else
                    post(REQ_WRITE, DSP_ADDR_PORT, 8'($urandom_range(0, 127)));
                post(REQ_WRITE, DSP_DATA_PORT, 8'($urandom));
                post(REQ_READ, DSP_DATA_PORT, 8'($urandom));
                post(REQ_READ, DSP_ADDR_PORT, 8'($urandom));
            end else if (pick < 73) begin
                post(REQ_READ, {PORT_PAGE, 4'($urandom)}, 8'($urandom));
            end else if (pick < 81) begin
                // boot rom fill, enable, read back, random disable
                n = $urandom_range(1, 4);
                idx = '0;
                repeat (n) begin
                    idx = ROM_IDX_W'($urandom);
                    a = 16'($urandom);
                    a[ROM_IDX_W-1:0] = idx;
                    post(REQ_LOAD, a, 8'($urandom));
                end
                post(REQ_WRITE, CONTROL_PORT, {1'b1, 7'($urandom)});
                post(REQ_READ, ROM_BASE | 16'(idx), 8'($urandom));
                post(REQ_READ, ROM_BASE | 16'($urandom_range(0, 63)), 8'($urandom));
                post(REQ_WRITE, CONTROL_PORT, 8'($urandom));
            end else if (pick < 87) begin
                post(REQ_IDLE, 16'($urandom), 8'($urandom));
            end else if (pick < 93) begin
                post(REQ_LOAD, 16'($urandom), 8'($urandom));
            end else begin
                post(req_t'($urandom), 16'($urandom), 8'($urandom));
            end
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = draw_wait(send_run, send_calm);
        end else begin
            if (s_valid && s_ready) begin
                rdata_q.push_back(cur_op);
                n_accepted++;
                send_gap = draw_wait(send_run, send_calm);
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (req_q.size() != 0 && !(req_q[0].drain && rdata_q.size() != 0)) begin
                    cur_op = req_q.pop_front();
                    s_valid      <= 1'b1;
                    s_req_type   <= cur_op.req;
                    s_addr       <= cur_op.addr;
                    s_write_data <= cur_op.wdata;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and in-order check
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_wait = draw_wait(recv_run, recv_calm);
        end else begin
            if (m_valid && m_ready) begin
                if (rdata_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: read_data %02h", m_read_data);
                end else begin
                    got_op = rdata_q.pop_front();
                    n_checked++;
                    if (m_read_data !== got_op.rdata) begin
                        errors++;
                        if (errors <= 10)
                            $display("read_data mismatch: req %0d addr %04h expected %02h got %02h",
                                     got_op.req, got_op.addr, got_op.rdata, m_read_data);
                    end
                end
                recv_wait = draw_wait(recv_run, recv_calm);
                if (n_checked == 500 || n_checked == 1300)
                    recv_wait = LONG_HOLD;
            end
            if (recv_wait != 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values of the cpu ports, write-only and timer ports
        post(REQ_READ, 16'h00f4, 8'h00);
        post(REQ_READ, 16'h00f7, 8'hff);
        post(REQ_READ, 16'h00f1, 8'h00);
        post(REQ_READ, 16'h00ff, 8'hff);
        // address and data extremes
        post(REQ_WRITE, 16'h0000, 8'h00);
        post(REQ_WRITE, 16'hffff, 8'hff);
        post(REQ_READ, 16'h0000, 8'hff);
        post(REQ_READ, 16'hffff, 8'h00);
        // dsp register through the latch
        post(REQ_WRITE, DSP_ADDR_PORT, 8'h7f);
        post(REQ_WRITE, DSP_DATA_PORT, 8'ha5);
        post(REQ_READ, DSP_DATA_PORT, 8'h00);
        // timer port write only reaches ram
        post(REQ_WRITE, 16'h00fc, 8'h33);
        post(REQ_READ, 16'h00fc, 8'h00);
        // high latch: data write goes to ram only, read uses low seven bits
        post(REQ_WRITE, DSP_ADDR_PORT, 8'hff);
        post(REQ_WRITE, DSP_DATA_PORT, 8'h3c);
        post(REQ_READ, DSP_DATA_PORT, 8'h00);
        post(REQ_READ, DSP_ADDR_PORT, 8'h00);
        post(REQ_WRITE, 16'h00f9, 8'h5a);
        post(REQ_READ, 16'h00f9, 8'h00);
        // boot rom window, write under the enabled rom
        post(REQ_LOAD, 16'hffc0, 8'h12);
        post(REQ_LOAD, 16'h003f, 8'hed);
        post(REQ_WRITE, CONTROL_PORT, 8'h80);
        post(REQ_READ, 16'hffc0, 8'h00);
        post(REQ_WRITE, 16'hffff, 8'h77);
        post(REQ_READ, 16'hffff, 8'h00);
        post(REQ_WRITE, CONTROL_PORT, 8'h7f);
        post(REQ_READ, 16'hffff, 8'h00);
        post(REQ_IDLE, 16'hffff, 8'hff);

        run_phase(8'hff, 8'hff, 8'hff, 8'hff);
        run_phase(8'h00, 8'h00, 8'h00, 8'h00);
        run_phase(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        run_phase(8'h01, 8'h80, 8'h7f, 8'hfe);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (errors == 0 && rdata_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/acbd_pkg.sv
rtl/core/acbd_apb.sv
rtl/core/acbd_access.sv
rtl/core/acbd_result.sv
rtl/core/audio_cpu_bus_decoder_unit.sv
dv/testbench.sv
